/* design/hltd_pkg.sv */
// shared types and constants for the header/length/tail deframer
`default_nettype none
package hltd_pkg;

    localparam int FUNC_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 9;
    localparam int FW_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h5a;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'ha5;

    // header needs more than this many bytes before the count byte is used
    localparam int MIN_AVAIL = 10;
    localparam int LEN_BASE  = 9;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PULL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL = 1'd1;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_PULL,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_CHECK,
        ST_COUNT,
        ST_TAIL1,
        ST_TAIL2,
        ST_QCHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_PULL_WAIT,
        ST_DONE
    } bk_state_t;

endpackage
`default_nettype wire

/* design/hltd_if.sv */
// channel interfaces: command input, result output, register write
`default_nettype none
interface hltd_in_if;
    logic                      valid;
    logic                      ready;
    logic [hltd_pkg::FUNC_W-1:0] func;
    logic [hltd_pkg::BYTE_W-1:0] rx_byte;
    modport source (output valid, func, rx_byte, input ready);
    modport sink (input valid, func, rx_byte, output ready);
endinterface

interface hltd_out_if;
    logic                        valid;
    logic                        ready;
    logic [hltd_pkg::BYTE_W-1:0] out_byte;
    logic                        out_valid;
    logic                        out_last;
    logic [hltd_pkg::FW_W-1:0]   frames_waiting;
    logic                        raw_overflow;
    logic                        queue_overflow;
    modport source (output valid, out_byte, out_valid, out_last, frames_waiting,
                    raw_overflow, queue_overflow, input ready);
    modport sink (input valid, out_byte, out_valid, out_last, frames_waiting,
                  raw_overflow, queue_overflow, output ready);
endinterface

interface hltd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hltd_pkg::CFG_IDX_W-1:0] index;
    logic [hltd_pkg::BYTE_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/header_length_tail_deframer.sv */
// top level of the sync-word / count-byte / tail deframer
//
//  channel  role     transaction carries
//  -------  -------  -------------------------------------------------------
//  in_ch    sink     func, rx_byte (push, pull, clear, no-op)
//  out_ch   source   out_byte, out_valid, out_last, frames_waiting, overflows
//  cfg_ch   sink     index, data (0 sync byte, 1 tail byte), always ready
//
// one result transaction per command transaction, in order
// pull reads one byte from the frame store; push scans the raw ring byte by byte up to the
//   header, then checks the count and tail bytes, and copies each byte of a good frame into
//   the frame store through the single read port of the raw ring
// every push rescans the raw ring from its head
// reset (rst_n low) empties the raw ring and the frame queue; stores hold no reset
// a two-entry command queue takes transactions while the result register is stalled
`default_nettype none
module header_length_tail_deframer #(
    parameter int RAW_DEPTH   = 512,
    parameter int STORE_DEPTH = 2048,
    parameter int FRAME_SLOTS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hltd_in_if.sink      in_ch,
    hltd_out_if.source   out_ch,
    hltd_cfg_if.sink     cfg_ch
);
    import hltd_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] sync_reg;
    logic [BYTE_W-1:0] tail_reg;

    // front to back command path
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_SYNC: sync_reg <= cfg_ch.data;
                REG_TAIL: tail_reg <= cfg_ch.data;
                default:
                begin
                end
            endcase
        end
    end

    // decode and buffer commands
    hltd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // raw ring, header search, frame queue and result register
    hltd_back #(
        .RAW_DEPTH   (RAW_DEPTH),
        .STORE_DEPTH (STORE_DEPTH),
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .sync_byte (sync_reg),
        .tail_byte (tail_reg),
        .out_ch    (out_ch)
    );

endmodule
`default_nettype wire

/* design/hltd_front.sv */
// front end: accepts commands, decodes the function code, two-entry queue
`default_nettype none
module hltd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    hltd_in_if.sink             in_ch,
    output logic                cmd_valid,
    input  wire logic           cmd_ready,
    output hltd_pkg::cmd_t      cmd
);
    import hltd_pkg::*;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push_in;
    logic        pop_out;
    op_t         op_dec;

    always_comb
    begin
        unique case (in_ch.func)
            FUNC_PUSH:  op_dec = OP_PUSH;
            FUNC_PULL:  op_dec = OP_PULL;
            FUNC_CLEAR: op_dec = OP_CLEAR;
            default:    op_dec = OP_NOP;
        endcase
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push_in     = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (cnt_reg != 2'd0);
    assign pop_out     = cmd_valid && cmd_ready;
    assign cmd         = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_in)
        begin
            q_reg[wr_ptr_reg] <= '{op: op_dec, data: in_ch.rx_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push_in)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_out)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push_in && !pop_out)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop_out && !push_in)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* design/hltd_back.sv */
// back end: raw ring buffer, header search sequencer, frame queue, result register
`default_nettype none
module hltd_back #(
    parameter int RAW_DEPTH   = 512,
    parameter int STORE_DEPTH = 2048,
    parameter int FRAME_SLOTS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cmd_valid,
    output logic                           cmd_ready,
    input  wire hltd_pkg::cmd_t            cmd,
    input  wire logic [hltd_pkg::BYTE_W-1:0] sync_byte,
    input  wire logic [hltd_pkg::BYTE_W-1:0] tail_byte,
    hltd_out_if.source                     out_ch
);
    import hltd_pkg::*;

    localparam int RW = $clog2(RAW_DEPTH);
    localparam int SW = $clog2(STORE_DEPTH);
    localparam int LW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int CW = $clog2(FRAME_SLOTS + 1);

    bk_state_t state_reg, state_next;

    logic [BYTE_W-1:0] raw_mem [RAW_DEPTH];
    logic [BYTE_W-1:0] frame_mem [STORE_DEPTH];
    logic [LEN_W-1:0]  size_mem [FRAME_SLOTS];
    logic [BYTE_W-1:0] raw_rd_reg;
    logic [BYTE_W-1:0] frame_rd_reg;
    logic [LEN_W-1:0]  size_rd_reg;

    logic [RW-1:0]    raw_head_reg, raw_head_next;
    logic [RW:0]      raw_fill_reg, raw_fill_next;
    logic [RW:0]      k_reg, k_next;
    logic             prev_reg, prev_next;
    logic [RW:0]      pos_reg, pos_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             t1_reg, t1_next;
    logic [LEN_W-1:0] j_reg, j_next;
    logic [SW-1:0]    store_head_reg, store_head_next;
    logic [SW:0]      store_fill_reg, store_fill_next;
    logic [LW-1:0]    size_head_reg, size_head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [LEN_W-1:0] pull_off_reg, pull_off_next;

    logic [BYTE_W-1:0] rb_reg, rb_next;
    logic              ov_reg, ov_next;
    logic              ol_reg, ol_next;
    logic              rov_reg, rov_next;
    logic              qov_reg, qov_next;

    logic              o_valid_reg;
    logic [BYTE_W-1:0] o_byte_reg;
    logic              o_ov_reg;
    logic              o_ol_reg;
    logic [FW_W-1:0]   o_fw_reg;
    logic              o_rov_reg;
    logic              o_qov_reg;

    // address generation
    logic [RW:0]     raw_off;
    logic [RW+1:0]   raw_sum;
    logic [RW-1:0]   raw_addr;
    logic            raw_we;
    logic            frame_we;
    logic            frame_off_fill;
    logic [SW+1:0]   frame_sum;
    logic [SW-1:0]   frame_addr;
    logic            size_we;
    logic [CW:0]     size_sum;
    logic [LW-1:0]   size_addr;
    logic            drop_en;
    logic [RW:0]     drop_n;
    logic [RW+1:0]   drop_sum;

    // shared decisions
    logic [RW:0]      avail;
    logic [LEN_W-1:0] len_calc;
    logic             found;
    logic             qfull;
    logic             pull_ok;
    logic             out_free;
    logic [LEN_W-1:0] pull_off_inc;

    assign raw_sum  = (RW+2)'(raw_head_reg) + (RW+2)'(raw_off);
    assign raw_addr = (raw_sum >= (RW+2)'(RAW_DEPTH)) ?
                      RW'(raw_sum - (RW+2)'(RAW_DEPTH)) : RW'(raw_sum);
    assign frame_sum = (SW+2)'(store_head_reg) +
                       (frame_off_fill ? (SW+2)'(store_fill_reg) : (SW+2)'(0));
    assign frame_addr = (frame_sum >= (SW+2)'(STORE_DEPTH)) ?
                        SW'(frame_sum - (SW+2)'(STORE_DEPTH)) : SW'(frame_sum);
    assign size_sum = (CW+1)'(size_head_reg) +
                      ((state_reg == ST_QCHK) ? (CW+1)'(count_reg) : (CW+1)'(0));
    assign size_addr = (size_sum >= (CW+1)'(FRAME_SLOTS)) ?
                       LW'(size_sum - (CW+1)'(FRAME_SLOTS)) : LW'(size_sum);
    assign drop_sum = (RW+2)'(raw_head_reg) + (RW+2)'(drop_n);

    assign avail    = raw_fill_reg - pos_reg;
    assign len_calc = LEN_W'({raw_rd_reg[6:0], 1'b0}) + LEN_W'(raw_rd_reg[6:0])
                      + LEN_W'(LEN_BASE);
    assign found    = prev_reg && (raw_rd_reg == sync_byte);
    assign qfull    = (count_reg >= CW'(FRAME_SLOTS)) ||
                      ((SW+2)'(store_fill_reg) + (SW+2)'(len_reg) > (SW+2)'(STORE_DEPTH));
    assign pull_ok  = (count_reg != '0) && (store_fill_reg != '0);
    assign out_free = !o_valid_reg || out_ch.ready;
    assign pull_off_inc = pull_off_reg + LEN_W'(1);

    assign cmd_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (raw_we)
        begin
            raw_mem[raw_addr] <= cmd.data;
        end
        raw_rd_reg <= raw_mem[raw_addr];
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_addr] <= raw_rd_reg;
        end
        frame_rd_reg <= frame_mem[frame_addr];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_addr] <= len_reg;
        end
        size_rd_reg <= size_mem[size_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_PUSH: state_next = ST_SCAN_RD;
                        OP_PULL: state_next = pull_ok ? ST_PULL_WAIT : ST_DONE;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_RD:   state_next = (k_reg == raw_fill_reg) ? ST_DONE : ST_SCAN_CMP;
            ST_SCAN_CMP:  state_next = found ? ST_CHECK : ST_SCAN_RD;
            ST_CHECK:     state_next = (avail <= (RW+1)'(MIN_AVAIL)) ? ST_DONE : ST_COUNT;
            ST_COUNT:
            begin
                if (raw_rd_reg[7] || (raw_rd_reg == '0) ||
                    ((RW+1)'(len_calc) > avail))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_TAIL1;
                end
            end
            ST_TAIL1:     state_next = ST_TAIL2;
            ST_TAIL2:     state_next = (t1_reg && (raw_rd_reg == tail_byte)) ?
                                       ST_QCHK : ST_DONE;
            ST_QCHK:      state_next = qfull ? ST_SCAN_RD : ST_COPY_RD;
            ST_COPY_RD:   state_next = (j_reg == len_reg) ? ST_SCAN_RD : ST_COPY_WR;
            ST_COPY_WR:   state_next = ST_COPY_RD;
            ST_PULL_WAIT: state_next = ST_DONE;
            ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        raw_head_next   = raw_head_reg;
        raw_fill_next   = raw_fill_reg;
        k_next          = k_reg;
        prev_next       = prev_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        t1_next         = t1_reg;
        j_next          = j_reg;
        store_head_next = store_head_reg;
        store_fill_next = store_fill_reg;
        size_head_next  = size_head_reg;
        count_next      = count_reg;
        pull_off_next   = pull_off_reg;
        rb_next         = rb_reg;
        ov_next         = ov_reg;
        ol_next         = ol_reg;
        rov_next        = rov_reg;
        qov_next        = qov_reg;
        raw_off         = '0;
        raw_we          = 1'b0;
        frame_we        = 1'b0;
        frame_off_fill  = 1'b0;
        size_we         = 1'b0;
        drop_en         = 1'b0;
        drop_n          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                raw_off = raw_fill_reg;
                if (cmd_valid)
                begin
                    rb_next  = '0;
                    ov_next  = 1'b0;
                    ol_next  = 1'b0;
                    rov_next = 1'b0;
                    qov_next = 1'b0;
                    k_next   = '0;
                    prev_next = 1'b0;
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            if (raw_fill_reg == (RW+1)'(RAW_DEPTH))
                            begin
                                rov_next = 1'b1;
                            end
                            else
                            begin
                                raw_we        = 1'b1;
                                raw_fill_next = raw_fill_reg + (RW+1)'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            store_fill_next = '0;
                            store_head_next = '0;
                            size_head_next  = '0;
                            pull_off_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                raw_off = k_reg;
            end
            ST_SCAN_CMP:
            begin
                if (found)
                begin
                    pos_next = k_reg - (RW+1)'(1);
                end
                else
                begin
                    prev_next = (raw_rd_reg == sync_byte);
                    k_next    = k_reg + (RW+1)'(1);
                end
            end
            ST_CHECK:
            begin
                raw_off = pos_reg + (RW+1)'(2);
            end
            ST_COUNT:
            begin
                len_next = len_calc;
                raw_off  = pos_reg + (RW+1)'(len_calc) - (RW+1)'(1);
                if (raw_rd_reg[7])
                begin
                    drop_en = 1'b1;
                    drop_n  = pos_reg + (RW+1)'(1);
                end
                else if (raw_rd_reg == '0)
                begin
                    drop_en = 1'b1;
                    drop_n  = pos_reg + (RW+1)'(LEN_BASE);
                end
            end
            ST_TAIL1:
            begin
                t1_next = (raw_rd_reg == tail_byte);
                raw_off = pos_reg + (RW+1)'(len_reg) - (RW+1)'(2);
            end
            ST_TAIL2:
            begin
                if (!(t1_reg && (raw_rd_reg == tail_byte)))
                begin
                    drop_en = 1'b1;
                    drop_n  = (RW+1)'(1);
                end
            end
            ST_QCHK:
            begin
                j_next = '0;
                if (qfull)
                begin
                    qov_next  = 1'b1;
                    drop_en   = 1'b1;
                    drop_n    = pos_reg + (RW+1)'(len_reg);
                    k_next    = '0;
                    prev_next = 1'b0;
                end
                else
                begin
                    size_we = 1'b1;
                end
            end
            ST_COPY_RD:
            begin
                raw_off = pos_reg + (RW+1)'(j_reg);
                if (j_reg == len_reg)
                begin
                    count_next = count_reg + CW'(1);
                    drop_en    = 1'b1;
                    drop_n     = pos_reg + (RW+1)'(len_reg);
                    k_next     = '0;
                    prev_next  = 1'b0;
                end
            end
            ST_COPY_WR:
            begin
                frame_we        = 1'b1;
                frame_off_fill  = 1'b1;
                store_fill_next = store_fill_reg + (SW+1)'(1);
                j_next          = j_reg + LEN_W'(1);
            end
            ST_PULL_WAIT:
            begin
                rb_next         = frame_rd_reg;
                ov_next         = 1'b1;
                store_head_next = (store_head_reg == SW'(STORE_DEPTH - 1)) ?
                                  '0 : store_head_reg + SW'(1);
                store_fill_next = store_fill_reg - (SW+1)'(1);
                if (pull_off_inc >= size_rd_reg)
                begin
                    ol_next        = 1'b1;
                    pull_off_next  = '0;
                    size_head_next = (size_head_reg == LW'(FRAME_SLOTS - 1)) ?
                                     '0 : size_head_reg + LW'(1);
                    count_next     = count_reg - CW'(1);
                end
                else
                begin
                    pull_off_next = pull_off_inc;
                end
            end
            default:
            begin
            end
        endcase

        if (drop_en)
        begin
            raw_head_next = (drop_sum >= (RW+2)'(RAW_DEPTH)) ?
                            RW'(drop_sum - (RW+2)'(RAW_DEPTH)) : RW'(drop_sum);
            raw_fill_next = raw_fill_reg - drop_n;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        len_reg <= len_next;
        t1_reg  <= t1_next;
        j_reg   <= j_next;
        rb_reg  <= rb_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            o_byte_reg <= rb_reg;
            o_ov_reg   <= ov_reg;
            o_ol_reg   <= ol_reg;
            o_fw_reg   <= FW_W'(count_reg);
            o_rov_reg  <= rov_reg;
            o_qov_reg  <= qov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            raw_head_reg   <= '0;
            raw_fill_reg   <= '0;
            k_reg          <= '0;
            prev_reg       <= 1'b0;
            store_head_reg <= '0;
            store_fill_reg <= '0;
            size_head_reg  <= '0;
            count_reg      <= '0;
            pull_off_reg   <= '0;
            ov_reg         <= 1'b0;
            ol_reg         <= 1'b0;
            rov_reg        <= 1'b0;
            qov_reg        <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            raw_head_reg   <= raw_head_next;
            raw_fill_reg   <= raw_fill_next;
            k_reg          <= k_next;
            prev_reg       <= prev_next;
            store_head_reg <= store_head_next;
            store_fill_reg <= store_fill_next;
            size_head_reg  <= size_head_next;
            count_reg      <= count_next;
            pull_off_reg   <= pull_off_next;
            ov_reg         <= ov_next;
            ol_reg         <= ol_next;
            rov_reg        <= rov_next;
            qov_reg        <= qov_next;
            if ((state_reg == ST_DONE) && out_free)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid          = o_valid_reg;
    assign out_ch.out_byte       = o_byte_reg;
    assign out_ch.out_valid      = o_ov_reg;
    assign out_ch.out_last       = o_ol_reg;
    assign out_ch.frames_waiting = o_fw_reg;
    assign out_ch.raw_overflow   = o_rov_reg;
    assign out_ch.queue_overflow = o_qov_reg;

endmodule
`default_nettype wire

/* design/hltd_checker.sv */
// port-level assertions for the deframer and their bind
`default_nettype none
module hltd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [7:0] res_byte,
    input wire logic       res_out_valid,
    input wire logic       res_out_last,
    input wire logic       res_raw_ov,
    input wire logic       res_queue_ov
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_byte))
        else $error("stalled result changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_out_last |-> res_out_valid)
        else $error("frame end without a frame byte");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_out_valid |-> res_byte == 8'd0)
        else $error("byte not zero without a frame byte");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_raw_ov || res_queue_ov) |-> !res_out_valid)
        else $error("overflow reported on a pull");

endmodule

bind header_length_tail_deframer hltd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (out_ch.valid),
    .res_ready     (out_ch.ready),
    .res_byte      (out_ch.out_byte),
    .res_out_valid (out_ch.out_valid),
    .res_out_last  (out_ch.out_last),
    .res_raw_ov    (out_ch.raw_overflow),
    .res_queue_ov  (out_ch.queue_overflow)
);
`default_nettype wire

/* sim/tb.sv */
// testbench for the header/length/tail deframer: directed and random traffic against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import hltd_pkg::*;

    localparam int RAW_SZ   = 512;
    localparam int STORE_SZ = 2048;
    localparam int SLOTS    = 16;
    localparam int WATCHDOG = 40000;

    // one expected result transaction
    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              out_last;
        logic [FW_W-1:0]   frames_waiting;
        logic              raw_overflow;
        logic              queue_overflow;
    } deframe_result_t;

    // predicts the deframer state and keeps the results still owed by the block
    class deframe_scoreboard;
        logic [BYTE_W-1:0] raw_ring[RAW_SZ];
        int                raw_head, raw_fill;
        logic [BYTE_W-1:0] frame_mem[STORE_SZ];
        int                frame_len[SLOTS];
        int                size_head, frame_cnt, mem_head, mem_fill, pull_pos;
        logic [BYTE_W-1:0] sync_val, tail_val;
        deframe_result_t   owed_q[$];
        int                errors, results_seen, frames_queued;

        function new();
            raw_head = 0; raw_fill = 0; size_head = 0; frame_cnt = 0;
            mem_head = 0; mem_fill = 0; pull_pos = 0;
            sync_val = SYNC_RESET; tail_val = TAIL_RESET;
            errors = 0; results_seen = 0; frames_queued = 0;
        endfunction

        function logic [BYTE_W-1:0] raw_byte(int i);
            return raw_ring[(raw_head + i) % RAW_SZ];
        endfunction

        function void raw_discard(int n);
            if (n > raw_fill)
                n = raw_fill;
            raw_head = (raw_head + n) % RAW_SZ;
            raw_fill -= n;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            if (idx == REG_SYNC)
                sync_val = val;
            else
                tail_val = val;
        endfunction

        // repeated header search after a push
        function void scan(ref logic qov);
            int pos, avail, cnt, len;
            bit found;
            forever
            begin
                found = 0;
                for (int i = 0; i + 1 < raw_fill; i++)
                begin
                    if (raw_byte(i) == sync_val && raw_byte(i + 1) == sync_val)
                    begin
                        pos = i;
                        found = 1;
                        break;
                    end
                end
                if (!found)
                    return;
                avail = raw_fill - pos;
                if (avail <= MIN_AVAIL)
                    return;
                cnt = raw_byte(pos + 2);
                // count of 128 or more drops the ring up to and including the first header byte
                if (cnt >= 128)
                begin
                    raw_discard(pos + 1);
                    return;
                end
                len = cnt * 3 + LEN_BASE;
                // count zero: drop a short stub
                if (cnt == 0)
                begin
                    raw_discard(pos + len);
                    return;
                end
                if (len > avail)
                    return;
                if (raw_byte(pos + len - 1) == tail_val && raw_byte(pos + len - 2) == tail_val)
                begin
                    if (frame_cnt >= SLOTS || mem_fill + len > STORE_SZ)
                        qov = 1;
                    else
                    begin
                        frame_len[(size_head + frame_cnt) % SLOTS] = len;
                        for (int k = 0; k < len; k++)
                        begin
                            frame_mem[(mem_head + mem_fill) % STORE_SZ] = raw_byte(pos + k);
                            mem_fill++;
                        end
                        frame_cnt++;
                        frames_queued++;
                    end
                    raw_discard(pos + len);
                end
                else
                begin
                    // bad tail: slip one byte
                    raw_discard(1);
                    return;
                end
            end
        endfunction

        function void note_command(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] data);
            deframe_result_t r;
            logic qov;
            r = '{default: '0};
            qov = 1'b0;
            if (func == FUNC_PUSH)
            begin
                if (raw_fill >= RAW_SZ)
                    r.raw_overflow = 1;
                else
                begin
                    raw_ring[(raw_head + raw_fill) % RAW_SZ] = data;
                    raw_fill++;
                end
                scan(qov);
                r.queue_overflow = qov;
            end
            else if (func == FUNC_PULL)
            begin
                if (frame_cnt > 0 && mem_fill > 0)
                begin
                    r.out_byte = frame_mem[mem_head];
                    r.out_valid = 1;
                    mem_head = (mem_head + 1) % STORE_SZ;
                    mem_fill--;
                    pull_pos++;
                    if (pull_pos >= frame_len[size_head])
                    begin
                        r.out_last = 1;
                        pull_pos = 0;
                        size_head = (size_head + 1) % SLOTS;
                        frame_cnt--;
                    end
                end
            end
            else if (func == FUNC_CLEAR)
            begin
                frame_cnt = 0; mem_fill = 0; mem_head = 0; size_head = 0; pull_pos = 0;
            end
            r.frames_waiting = frame_cnt[FW_W-1:0];
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void check_result(deframe_result_t got);
            deframe_result_t want;
            results_seen++;
            if (owed_q.size() == 0)
            begin
                $display("%0t: unexpected result transaction, out_byte %h", $time, got.out_byte);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.out_valid !== want.out_valid)
            begin
                $display("%0t: out_valid expected %b actual %b", $time, want.out_valid,
                         got.out_valid);
                errors++;
            end
            if (got.out_last !== want.out_last)
            begin
                $display("%0t: out_last expected %b actual %b", $time, want.out_last, got.out_last);
                errors++;
            end
            if (got.frames_waiting !== want.frames_waiting)
            begin
                $display("%0t: frames_waiting expected %0d actual %0d", $time,
                         want.frames_waiting, got.frames_waiting);
                errors++;
            end
            if (got.raw_overflow !== want.raw_overflow)
            begin
                $display("%0t: raw_overflow expected %b actual %b", $time, want.raw_overflow,
                         got.raw_overflow);
                errors++;
            end
            if (got.queue_overflow !== want.queue_overflow)
            begin
                $display("%0t: queue_overflow expected %b actual %b", $time,
                         want.queue_overflow, got.queue_overflow);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;

    hltd_in_if  in_ch();
    hltd_out_if out_ch();
    hltd_cfg_if cfg_ch();

    header_length_tail_deframer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    deframe_scoreboard sb = new();
    bit no_idle = 0;     // set for stretches of back-to-back traffic
    int stall_cycles = 0;
    int pushes, pulls, clears;

    always #6 clk = ~clk;

    initial
    begin
        in_ch.valid = 0; in_ch.func = FUNC_PUSH; in_ch.rx_byte = 0;
        cfg_ch.valid = 0; cfg_ch.index = REG_SYNC; cfg_ch.data = 0;
        out_ch.ready = 0;
    end

    // monitor: note commands and register writes, check results, all on pre-edge values
    always @(posedge clk)
    begin
        deframe_result_t got;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.note_command(in_ch.func, in_ch.rx_byte);
            if (out_ch.valid && out_ch.ready)
            begin
                got.out_byte = out_ch.out_byte;
                got.out_valid = out_ch.out_valid;
                got.out_last = out_ch.out_last;
                got.frames_waiting = out_ch.frames_waiting;
                got.raw_overflow = out_ch.raw_overflow;
                got.queue_overflow = out_ch.queue_overflow;
                sb.check_result(got);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if (stall_cycles >= WATCHDOG)
        begin
            $display("watchdog expired at %0t", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls before each transaction
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    task automatic send_cmd(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.func <= func;
        in_ch.rx_byte <= data;
        do
            @(posedge clk);
        while (!in_ch.ready);
        case (func)
            FUNC_PUSH:  pushes++;
            FUNC_PULL:  pulls++;
            FUNC_CLEAR: clears++;
            default: ;
        endcase
    endtask

    task automatic push_byte(logic [BYTE_W-1:0] b);
        send_cmd(FUNC_PUSH, b);
    endtask

    // sender holds off until every owed result has come back
    task automatic drain();
        in_ch.valid <= 0;
        @(posedge clk);
        while (sb.owed_q.size() != 0)
            @(posedge clk);
    endtask

    // waits for the block to go idle before writing
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
        drain();
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 0;
    endtask

    // header, count, payload and two trailer bytes; bad_tail corrupts one trailer byte
    task automatic push_frame(int cnt, bit bad_tail);
        int len;
        len = cnt * 3 + LEN_BASE;
        push_byte(sb.sync_val);
        push_byte(sb.sync_val);
        push_byte(cnt[7:0]);
        for (int k = 3; k < len - 2; k++)
            push_byte($urandom_range(0, 255));
        if (bad_tail)
        begin
            push_byte(sb.tail_val ^ 8'h01);
            push_byte(sb.tail_val);
        end
        else
        begin
            push_byte(sb.tail_val);
            push_byte(sb.tail_val);
        end
    endtask

    task automatic pull_burst(int n);
        for (int k = 0; k < n; k++)
            send_cmd(FUNC_PULL, $urandom_range(0, 255));
    endtask

    initial
    begin
        int choice, items;
        logic [BYTE_W-1:0] b;
        pushes = 0; pulls = 0; clears = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty pull, no-op, field extremes, short frame, clear
        send_cmd(FUNC_PULL, 8'h00);
        send_cmd(OP_NOP, 8'hff);
        push_byte(8'h00);
        push_byte(8'hff);
        push_frame(1, 0);
        pull_burst(3);
        send_cmd(FUNC_CLEAR, 8'h00);
        send_cmd(FUNC_PULL, 8'hff);
        drain();

        // extreme register values, then count zero, large count and bad tail
        write_reg(REG_SYNC, 8'h00);
        write_reg(REG_TAIL, 8'hff);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
        for (int k = 0; k < 9; k++)
            push_byte(8'h77);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'd200);
        for (int k = 0; k < 9; k++)
            push_byte(8'h33);
        push_frame(1, 1);
        push_frame(2, 0);
        pull_burst(20);
        drain();
        write_reg(REG_SYNC, 8'hff);
        write_reg(REG_TAIL, 8'h00);
        push_frame(1, 0);
        pull_burst(6);
        drain();
        write_reg(REG_SYNC, SYNC_RESET);
        write_reg(REG_TAIL, TAIL_RESET);

        // random: mostly well-formed frames with random content
        items = 0;
        while (items < 40)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            choice = $urandom_range(0, 99);
            if (choice < 45)
            begin
                choice = $urandom_range(1, 8);
                push_frame(choice, $urandom_range(0, 7) == 0);
                items += choice * 3 + LEN_BASE;
            end
            else if (choice < 60)
            begin
                push_byte($urandom_range(0, 255));
                items++;
            end
            else if (choice < 85)
            begin
                choice = $urandom_range(1, 30);
                pull_burst(choice);
                items += choice;
            end
            else if (choice < 88)
            begin
                send_cmd($urandom_range(0, 1) ? FUNC_CLEAR : OP_NOP, $urandom_range(0, 255));
                items++;
            end
            else if (choice < 90)
            begin
                // fill the frame queue past its slots
                for (int k = 0; k < 18; k++)
                    push_frame(1, 0);
                items += 18 * 12;
            end
            else if (choice < 93)
            begin
                // occasional large frame
                choice = $urandom_range(100, 127);
                push_frame(choice, 0);
                items += choice * 3 + LEN_BASE;
            end
            else if (choice < 96)
            begin
                push_frame(0, 0);
                items += 9;
            end
            else
            begin
                write_reg(REG_SYNC, $urandom_range(0, 255));
                write_reg(REG_TAIL, $urandom_range(0, 255));
            end
        end
        no_idle = 0;
        pull_burst(40);
        drain();

        // raw ring overflow: no header can form, then drain via a new sync value
        write_reg(REG_SYNC, 8'h11);
        write_reg(REG_TAIL, 8'h44);
        for (int k = 0; k < RAW_SZ + 8; k++)
        begin
            if (k % 37 == 0)
                b = 8'h33;
            else
                do
                    b = $urandom_range(0, 255);
                while (b == 8'h11 || b == 8'h33);
            push_byte(b);
            if (k % 37 == 0)
                push_byte(8'h33);
        end
        write_reg(REG_SYNC, 8'h33);
        for (int k = 0; k < 40; k++)
            push_byte($urandom_range(0, 255));
        pull_burst(10);

        drain();
        repeat (60) @(posedge clk);
        $display("covered %0d pushes, %0d pulls, %0d clears; %0d frames queued, %0d results",
                 pushes, pulls, clears, sb.frames_queued, sb.results_seen);
        $display("including count zero, large count, bad trailer and raw ring overflow");
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
